@@ src/size_class_free_list_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// Size-class free-list allocator: assertion macros
// Shared concurrent assertion forms used by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCFLA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCFLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/scfla_pkg.sv @@
// ----------------------------------------------------------------------------
// Size-class free-list allocator package
// Geometry constants, beat types, codes and control structures.
// ----------------------------------------------------------------------------
package scfla_pkg;

    // Pool geometry.
    localparam int POOL_BYTES      = 4096;
    localparam int MIN_CLASS_BYTES = 8;
    localparam int POOL_SHIFT      = $clog2(POOL_BYTES);
    localparam int MIN_SHIFT       = $clog2(MIN_CLASS_BYTES);
    localparam int NUM_CLASSES     = POOL_SHIFT - MIN_SHIFT;
    localparam int CLASS_W         = $clog2(NUM_CLASSES);
    localparam int MAX_SLOTS       = POOL_BYTES / MIN_CLASS_BYTES;
    localparam int SLOT_W          = $clog2(MAX_SLOTS);
    localparam int COUNT_W         = SLOT_W + 1;
    localparam int LINK_DEPTH      = 2 * MAX_SLOTS - 2;
    localparam int LINK_AW         = $clog2(LINK_DEPTH);
    localparam int BASE_W          = LINK_AW + 1;
    localparam int LINK_W          = SLOT_W + 1;

    // Field widths.
    localparam int SIZE_W          = 16;
    localparam int ADDR_W          = 16;
    localparam int CLASS_BYTES_W   = 12;

    // Request function codes.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERSIZE  = 2'd1,
        ST_BAD_SIZE  = 2'd2,
        ST_EXHAUSTED = 2'd3
    } t_status;

    typedef struct packed {
        logic                func;
        logic [SIZE_W-1:0]   request_size;
        logic [ADDR_W-1:0]   address;
    } t_in_item;

    typedef struct packed {
        t_status                    status;
        logic [ADDR_W-1:0]          block_address;
        logic [CLASS_BYTES_W-1:0]   class_bytes;
    } t_out_item;

    // Controller state.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;
        logic commit;
        logic pop_rd;
        logic pop_commit;
    } t_ctrl_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic is_pop;
        logic out_free;
    } t_dp_status;

endpackage

@@ src/scfla_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/scfla_ctrl.sv @@
// ----------------------------------------------------------------------------
// Size-class free-list allocator controller
// Sequences accept, execute and free-list pop for one request at a time.
// ----------------------------------------------------------------------------
module scfla_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  scfla_pkg::t_dp_status  i_status,
    output scfla_pkg::t_ctrl_cmd   o_cmd
);

    import scfla_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // Wait until the output register can take the result beat.
                if (i_status.out_free) begin
                    if (i_status.is_pop) begin
                        o_cmd.pop_rd = 1'b1;
                        n_state      = S_POP;
                    end else begin
                        o_cmd.commit = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end
            S_POP: begin
                o_cmd.pop_commit = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/scfla_dp.sv @@
// ----------------------------------------------------------------------------
// Size-class free-list allocator datapath
// Class lookup, per-class list heads and fill counts, link memory, result.
// ----------------------------------------------------------------------------
`include "size_class_free_list_allocator_defines.svh"

module scfla_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  scfla_pkg::t_in_item    i_in_data,
    input  scfla_pkg::t_ctrl_cmd   i_cmd,
    output scfla_pkg::t_dp_status  o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output scfla_pkg::t_out_item   o_out_data
);

    import scfla_pkg::*;

    t_in_item                 r_req;
    t_out_item                r_out_data;
    t_out_item                n_out_data;
    logic                     r_out_valid;

    logic [SLOT_W-1:0]        r_head_slot  [NUM_CLASSES];
    logic                     r_head_valid [NUM_CLASSES];
    logic [COUNT_W-1:0]       r_fresh      [NUM_CLASSES];

    t_status                  w_cls_st;
    logic                     w_cls_ok;
    logic                     w_hit;
    logic [CLASS_W-1:0]       w_k;
    logic [CLASS_BYTES_W-1:0] w_cb;
    logic [COUNT_W-1:0]       w_slots;
    logic [SLOT_W-1:0]        w_head_slot;
    logic                     w_head_valid;
    logic [COUNT_W-1:0]       w_fresh;
    logic                     w_is_alloc;
    logic                     w_is_pop;
    logic                     w_can_fresh;
    logic [SLOT_W-1:0]        w_off;
    logic [SLOT_W-1:0]        w_free_slot;
    logic                     w_free_hit;
    logic [SLOT_W-1:0]        w_alloc_slot;
    logic [SLOT_W-1:0]        w_link_slot;
    logic [BASE_W-1:0]        w_base;
    logic [BASE_W-1:0]        w_idx_sum;
    logic [LINK_AW-1:0]       w_idx;
    logic [ADDR_W-1:0]        w_blk;
    logic                     w_link_we;
    logic [LINK_W-1:0]        w_link_rdata;

    // Request register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_data;
        end
    end

    // Size class lookup: smallest class that holds the request.
    always_comb begin
        w_k      = '0;
        w_hit    = 1'b0;
        w_cls_st = ST_OK;
        if (r_req.request_size > SIZE_W'(POOL_BYTES / 2)) begin
            w_cls_st = ST_OVERSIZE;
        end else if (r_req.request_size == '0) begin
            w_cls_st = ST_BAD_SIZE;
        end else begin
            for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
                if ({1'b0, r_req.request_size} <= ((SIZE_W + 1)'(MIN_CLASS_BYTES) << i)) begin
                    w_k   = CLASS_W'(i);
                    w_hit = 1'b1;
                end
            end
            if (!w_hit) begin
                w_cls_st = ST_BAD_SIZE;
            end
        end
    end

    assign w_cls_ok = (w_cls_st == ST_OK);

    // Per-class quantities.
    assign w_cb         = CLASS_BYTES_W'(MIN_CLASS_BYTES) << w_k;
    assign w_slots      = COUNT_W'(MAX_SLOTS) >> w_k;
    assign w_head_slot  = r_head_slot[w_k];
    assign w_head_valid = r_head_valid[w_k];
    assign w_fresh      = r_fresh[w_k];
    assign w_base       = BASE_W'(2 * MAX_SLOTS) - (BASE_W'(2 * MAX_SLOTS) >> w_k);

    assign w_is_alloc   = (r_req.func == FUNC_ALLOC);
    assign w_is_pop     = w_cls_ok && w_is_alloc && w_head_valid;
    assign w_can_fresh  = (w_fresh < w_slots);

    // Free: offset within the pool region, rounded down to its slot.
    assign w_off        = r_req.address[POOL_SHIFT-1:MIN_SHIFT];
    assign w_free_slot  = w_off >> w_k;
    assign w_free_hit   = ({1'b0, w_free_slot} < w_fresh);

    assign w_alloc_slot = w_head_valid ? w_head_slot : w_fresh[SLOT_W-1:0];

    // Link memory index: class base plus slot.
    assign w_link_slot  = w_is_alloc ? w_head_slot : w_free_slot;
    assign w_idx_sum    = w_base + BASE_W'(w_link_slot);
    assign w_idx        = w_idx_sum[LINK_AW-1:0];

    assign w_blk = (ADDR_W'(w_k) << POOL_SHIFT)
                 | ((ADDR_W'(w_alloc_slot) << MIN_SHIFT) << w_k);

    assign w_link_we = i_cmd.commit && w_cls_ok && !w_is_alloc && w_free_hit;

    scfla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_waddr (w_idx),
        .i_wdata ({w_head_valid, w_head_slot}),
        .i_re    (i_cmd.pop_rd),
        .i_raddr (w_idx),
        .o_rdata (w_link_rdata)
    );

    // Result beat for the current request.
    always_comb begin
        n_out_data = '0;
        if (!w_cls_ok) begin
            n_out_data.status = w_cls_st;
        end else if (w_is_alloc) begin
            if (w_head_valid || w_can_fresh) begin
                n_out_data.status        = ST_OK;
                n_out_data.block_address = w_blk;
                n_out_data.class_bytes   = w_cb;
            end else begin
                n_out_data.status = ST_EXHAUSTED;
            end
        end else begin
            n_out_data.status      = ST_OK;
            n_out_data.class_bytes = w_cb;
        end
    end

    // List heads, fill counts and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_head_slot[i]  <= '0;
                r_head_valid[i] <= 1'b0;
                r_fresh[i]      <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit && w_cls_ok) begin
                if (w_is_alloc && !w_head_valid && w_can_fresh) begin
                    r_fresh[w_k] <= w_fresh + 1'b1;
                end
                if (!w_is_alloc && w_free_hit) begin
                    r_head_slot[w_k]  <= w_free_slot;
                    r_head_valid[w_k] <= 1'b1;
                end
            end
            if (i_cmd.pop_commit) begin
                r_head_slot[w_k]  <= w_link_rdata[SLOT_W-1:0];
                r_head_valid[w_k] <= w_link_rdata[SLOT_W];
            end
            if (i_cmd.commit || i_cmd.pop_commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit || i_cmd.pop_commit) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_status.is_pop   = w_is_pop;
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

    // Checks on sequencing and result formatting.
    `SCFLA_ASSERT_SAME(a_commit_room, i_clk, i_rst_n, i_cmd.commit || i_cmd.pop_commit, !r_out_valid || !i_out_stall, "Result written over a beat not yet taken.")
    `SCFLA_ASSERT_NEXT(a_pop_completes, i_clk, i_rst_n, i_cmd.pop_rd, i_cmd.pop_commit, "Link read not followed by pop completion.")
    `SCFLA_ASSERT_SAME(a_pop_has_head, i_clk, i_rst_n, i_cmd.pop_rd, w_is_pop, "Link read issued without a valid list head.")
    `SCFLA_ASSERT_SAME(a_fail_zeroed, i_clk, i_rst_n, r_out_valid && (r_out_data.status != ST_OK), (r_out_data.block_address == '0) && (r_out_data.class_bytes == '0), "Failed result carries a non-zero field.")

endmodule

@@ src/size_class_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// Size-class free-list allocator
// Power-of-two size classes, each with a LIFO free list and a fresh-slot count.
// ----------------------------------------------------------------------------
// Each request allocates or frees one block and returns exactly one result
// beat. A request is accepted only when the block is idle; it then has
// accept and execute steps, and a pop step for an allocation served from a
// class's free list, because the next list head comes from the link memory,
// whose read data is registered. A result waiting in the output register
// holds back the execute step until it is taken. The link memory needs no
// clearing after reset: an entry is only read after a free has written it.
module size_class_free_list_allocator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  scfla_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output scfla_pkg::t_out_item o_out_data
);

    import scfla_pkg::*;

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    // Request sequencer.
    scfla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Allocation datapath and output register.
    scfla_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Size-class free-list allocator testbench
// Sends allocate and free requests through the valid/stall handshake. Every
// request is predicted from an internal copy of the per-class free lists,
// fresh-slot counts and slot links. Each reply beat is then checked, field by
// field, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench;
    import scfla_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    // Predicted allocator state, mirroring the block after reset.
    int class_free_head   [NUM_CLASSES];
    bit class_head_valid  [NUM_CLASSES];
    int class_fresh_count [NUM_CLASSES];
    int slot_link_next    [LINK_DEPTH];
    bit slot_link_valid   [LINK_DEPTH];

    // Replies still owed by the block, oldest first, and blocks held live.
    t_out_item replies_due[$];
    t_out_item held_blocks[$];

    int failures        = 0;
    int replies_checked = 0;
    int requests_sent   = 0;
    int pops_served     = 0;
    int fresh_served    = 0;
    int exhausted_seen  = 0;
    int sizes_rejected  = 0;
    int frees_applied   = 0;
    int frees_ignored   = 0;
    int cycle_count     = 0;

    // Sender burst control and receiver stall pattern.
    bit       gaps_on     = 1'b1;
    int       burst_left  = 1;
    logic [1:0] stall_style = 2'd1;
    int       stall_left  = 0;

    size_class_free_list_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    // Work out the reply to one request and update the predicted state.
    function automatic t_out_item predict_allocator_reply(input t_in_item req);
        t_out_item reply;
        int        sz;
        int        addr;
        int        cls;
        int        cb;
        int        base;
        int        slot;
        bit        found;
        reply        = '0;
        reply.status = ST_OK;
        sz           = req.request_size;
        addr         = req.address;
        found        = 1'b0;
        cls          = 0;
        for (int j = 0; j < NUM_CLASSES; j++) begin
            if (!found && (MIN_CLASS_BYTES << j) <= POOL_BYTES / 2 &&
                sz <= (MIN_CLASS_BYTES << j)) begin
                found = 1'b1;
                cls   = j;
            end
        end
        if (sz * 2 > POOL_BYTES) begin
            reply.status = ST_OVERSIZE;
            sizes_rejected++;
            return reply;
        end
        if (sz == 0 || !found) begin
            reply.status = ST_BAD_SIZE;
            sizes_rejected++;
            return reply;
        end
        cb   = MIN_CLASS_BYTES << cls;
        base = 0;
        for (int j = 0; j < cls; j++) begin
            base += POOL_BYTES / (MIN_CLASS_BYTES << j);
        end
        if (req.func == FUNC_ALLOC) begin
            if (class_head_valid[cls]) begin
                slot                  = class_free_head[cls];
                class_free_head[cls]  = slot_link_next[base + slot];
                class_head_valid[cls] = slot_link_valid[base + slot];
                pops_served++;
            end else if (class_fresh_count[cls] < POOL_BYTES / cb) begin
                slot = class_fresh_count[cls];
                class_fresh_count[cls]++;
                fresh_served++;
            end else begin
                reply.status = ST_EXHAUSTED;
                exhausted_seen++;
                return reply;
            end
            reply.block_address = 16'(cls * POOL_BYTES + slot * cb);
            reply.class_bytes   = 12'(cb);
            return reply;
        end
        // Only the offset within a pool counts; it is rounded down to its slot.
        slot              = (addr % POOL_BYTES) / cb;
        reply.class_bytes = 12'(cb);
        if (slot < class_fresh_count[cls]) begin
            slot_link_next[base + slot]  = class_free_head[cls];
            slot_link_valid[base + slot] = class_head_valid[cls];
            class_free_head[cls]         = slot;
            class_head_valid[cls]        = 1'b1;
            frees_applied++;
        end else begin
            frees_ignored++;
        end
        return reply;
    endfunction

    // A random size that rounds up to the given class.
    function automatic logic [SIZE_W-1:0] size_in_class(input int cb);
        if (cb <= MIN_CLASS_BYTES) begin
            return SIZE_W'($urandom_range(1, cb));
        end
        return SIZE_W'($urandom_range(cb / 2 + 1, cb));
    endfunction

    // Present one request and hold it until accepted, then record its reply.
    // Called and returning on a rising edge; may insert a gap after a burst.
    task automatic send_request(input t_in_item req);
        t_out_item reply;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
        reply = predict_allocator_reply(req);
        replies_due = {replies_due, reply};
        requests_sent++;
        if (req.func == FUNC_ALLOC && reply.status == ST_OK) begin
            held_blocks = {held_blocks, reply};
        end
        if (gaps_on) begin
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 12);
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_fields(input logic func, input int sz, input int addr);
        t_in_item req;
        req.func         = func;
        req.request_size = SIZE_W'(sz);
        req.address      = ADDR_W'(addr);
        send_request(req);
    endtask

    // Hold off the sender until every owed reply has come back.
    task automatic wait_for_replies();
        i_in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Size rounding: zero, the smallest class, a class edge, the largest
    // class and sizes just over and far over it.
    task automatic test_request_sizes();
        send_fields(FUNC_ALLOC, 0, 0);
        send_fields(FUNC_ALLOC, 1, 0);
        send_fields(FUNC_ALLOC, 8, 16'hFFFF);
        send_fields(FUNC_ALLOC, 9, 0);
        send_fields(FUNC_ALLOC, 2048, 0);
        send_fields(FUNC_ALLOC, 2049, 0);
        send_fields(FUNC_ALLOC, 16'hFFFF, 0);
        send_fields(FUNC_ALLOC, 16'h8000, 0);
    endtask

    // Frees: a slot never handed out, a misaligned free with region bits set,
    // a double free, then allocations that must pop in LIFO order.
    task automatic test_free_paths();
        send_fields(FUNC_FREE, 16, 4096 + 16 * 5);
        send_fields(FUNC_FREE, 5, 16'hF000 | 11);
        send_fields(FUNC_FREE, 1, 0);
        send_fields(FUNC_FREE, 8, 0);
        send_fields(FUNC_FREE, 0, 0);
        send_fields(FUNC_ALLOC, 4, 0);
        send_fields(FUNC_ALLOC, 4, 0);
        send_fields(FUNC_ALLOC, 4, 0);
        send_fields(FUNC_ALLOC, 4, 0);
    endtask

    // The largest class has two slots: run it dry, free one, reuse it.
    task automatic test_class_exhaustion();
        send_fields(FUNC_ALLOC, 2048, 0);
        send_fields(FUNC_ALLOC, 1500, 0);
        send_fields(FUNC_FREE, 1025, 8 * POOL_BYTES);
        send_fields(FUNC_ALLOC, 2000, 0);
        send_fields(FUNC_ALLOC, 2048, 0);
    endtask

    // Mostly well-formed allocate/free traffic over live blocks, with some
    // double frees, misaligned and out-of-region frees, and raw noise.
    task automatic test_random_traffic(input int count);
        t_in_item  req;
        t_out_item blk;
        int        pick;
        int        roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                req.func         = 1'($urandom_range(0, 1));
                req.request_size = SIZE_W'($urandom_range(0, 65535));
                req.address      = ADDR_W'($urandom_range(0, 65535));
            end else if (roll < 54 || held_blocks.size() == 0) begin
                req.func         = FUNC_ALLOC;
                req.request_size =
                    size_in_class(MIN_CLASS_BYTES << $urandom_range(0, NUM_CLASSES - 1));
                req.address      = ADDR_W'($urandom_range(0, 65535));
            end else begin
                pick = $urandom_range(0, held_blocks.size() - 1);
                blk  = held_blocks[pick];
                // Occasionally keep the block so that it gets freed twice.
                if ($urandom_range(0, 9) != 0) begin
                    held_blocks.delete(pick);
                end
                req.func         = FUNC_FREE;
                req.request_size = size_in_class(blk.class_bytes);
                req.address      = blk.block_address;
                if ($urandom_range(0, 1) == 1) begin
                    req.address += ADDR_W'($urandom_range(0, blk.class_bytes - 1));
                end
                if ($urandom_range(0, 3) == 0) begin
                    req.address[ADDR_W-1:ADDR_W-4] = 4'($urandom_range(0, 15));
                end
            end
            send_request(req);
        end
    endtask

    // Receiver stall pattern: none, short random stalls or longer runs.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            if (stall_style == 2'd1 && $urandom_range(0, 3) == 0) begin
                stall_left <= $urandom_range(1, 3);
            end else if (stall_style == 2'd2 && $urandom_range(0, 5) == 0) begin
                stall_left <= $urandom_range(2, 9);
            end
        end
    end

    // Reply checking: inputs only change at the rising edge, so a beat seen
    // valid and unstalled here is the one taken at the next edge.
    always @(negedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (replies_due.size() == 0) begin
                $display("%0t: reply beat with none outstanding: status %0d address %0d class %0d",
                         $time, o_out_data.status, o_out_data.block_address,
                         o_out_data.class_bytes);
                failures++;
            end else begin
                want = replies_due.pop_front();
                replies_checked++;
                if (o_out_data.status !== want.status) begin
                    $display("%0t: status expected %0d, actual %0d",
                             $time, want.status, o_out_data.status);
                    failures++;
                end
                if (o_out_data.block_address !== want.block_address) begin
                    $display("%0t: block_address expected %0d, actual %0d",
                             $time, want.block_address, o_out_data.block_address);
                    failures++;
                end
                if (o_out_data.class_bytes !== want.class_bytes) begin
                    $display("%0t: class_bytes expected %0d, actual %0d",
                             $time, want.class_bytes, o_out_data.class_bytes);
                    failures++;
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d replies outstanding",
                     cycle_count, replies_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_request_sizes();
        test_free_paths();
        test_class_exhaustion();
        wait_for_replies();

        test_random_traffic(400);

        // A stretch with no idling on either side.
        gaps_on     = 1'b0;
        stall_style <= 2'd0;
        test_random_traffic(250);
        wait_for_replies();

        gaps_on     = 1'b1;
        stall_style <= 2'd2;
        test_random_traffic(400);
        wait_for_replies();

        $display("Sent %0d requests, checked %0d replies in %0d cycles.",
                 requests_sent, replies_checked, cycle_count);
        $display("Fresh %0d, popped %0d, exhausted %0d, bad or oversize %0d, freed %0d, ignored %0d.",
                 fresh_served, pops_served, exhausted_seen, sizes_rejected,
                 frees_applied, frees_ignored);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/scfla_pkg.sv
src/scfla_ram.sv
src/scfla_ctrl.sv
src/scfla_dp.sv
src/size_class_free_list_allocator.sv
bench/testbench.sv
